@@ hw/rtl/dtrc_pkg.sv @@
// Package for the dimuon road cut block: pipeline depth, field widths,
// register indexes, cut result codes and the per-road summary struct.
// No dependencies.
package dtrc_pkg;

    // Pipeline depth from input beat to output register.
    localparam int NUM_STAGES = 5;

    // Fixed field widths.
    localparam int SLOPE_W = 16;
    localparam int DEPTH_W = 10;
    localparam int HITS_W  = 4;
    localparam int MSLOPE_W = 15;
    localparam int COS_W   = 16;
    localparam int CFG_W   = 16;
    localparam int MAG_W   = 32;

    // One in Q3.12, squared (2^24).
    localparam logic [MAG_W-1:0] ONE_SQ = 32'd16777216;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_DEPTH_THRESHOLD = 2'd0,
        REG_MIN_HIT_COUNT   = 2'd1,
        REG_MIN_SLOPE       = 2'd2,
        REG_COS_ANGLE_LIMIT = 2'd3
    } cfg_reg_t;

    // First failing cut.
    typedef enum logic [2:0] {
        REASON_PASS  = 3'd0,
        REASON_DEPTH = 3'd1,
        REASON_HITS  = 3'd2,
        REASON_SLOPE = 3'd3,
        REASON_ANGLE = 3'd4
    } reason_t;

    // What one road lane found.
    typedef struct packed {
        logic             depth_ok;
        logic             count_ok;
        logic             slope_ok;
        logic [MAG_W-1:0] mag;
    } lane_res_t;

endpackage

@@ hw/rtl/dtrc_lane.sv @@
// One road lane: depth, hit count and slope magnitude cuts for one track.
// Two pipeline stages driven by stage enables from the top level.
// Depends on dtrc_pkg.
module dtrc_lane
    import dtrc_pkg::*;
#(
    parameter int PATTERN_BITS = 10
)
(
    input  logic                      clk,
    input  logic [1:0]                en,
    input  logic [PATTERN_BITS-1:0]   pattern,
    input  logic signed [SLOPE_W-1:0] slope_x,
    input  logic signed [SLOPE_W-1:0] slope_y,
    input  logic [DEPTH_W-1:0]        depth_threshold,
    input  logic [HITS_W-1:0]         min_hit_count,
    input  logic [2*MSLOPE_W-1:0]     min_slope_sq,
    output lane_res_t                 res
);

    localparam int CNT_W  = $clog2(PATTERN_BITS + 1);
    localparam int DCMP_W = (PATTERN_BITS > DEPTH_W) ? PATTERN_BITS : DEPTH_W;
    localparam int HCMP_W = (CNT_W > HITS_W) ? CNT_W : HITS_W;

    logic [CNT_W-1:0]        ones;
    logic signed [2*SLOPE_W-1:0] prod_x;
    logic signed [2*SLOPE_W-1:0] prod_y;
    logic [MAG_W-2:0]        sq_x_reg;
    logic [MAG_W-2:0]        sq_y_reg;
    logic                    depth_ok_reg;
    logic                    count_ok_reg;
    logic [MAG_W-1:0]        mag;
    lane_res_t               res_reg;

    // Count the set plane bits of the pattern.
    always_comb
    begin
        ones = '0;
        for (int i = 0; i < PATTERN_BITS; i++)
        begin
            ones = ones + CNT_W'(pattern[i]);
        end
    end

    assign prod_x = slope_x * slope_x;
    assign prod_y = slope_y * slope_y;

    // First stage: squares of the slopes and the pattern cuts.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sq_x_reg     <= prod_x[MAG_W-2:0];
            sq_y_reg     <= prod_y[MAG_W-2:0];
            depth_ok_reg <= DCMP_W'(pattern) >= DCMP_W'(depth_threshold);
            count_ok_reg <= HCMP_W'(ones) >= HCMP_W'(min_hit_count);
        end
    end

    // Second stage: squared magnitude against the squared minimum slope.
    assign mag = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            res_reg.depth_ok <= depth_ok_reg;
            res_reg.count_ok <= count_ok_reg;
            res_reg.slope_ok <= mag >= MAG_W'(min_slope_sq);
            res_reg.mag      <= mag;
        end
    end

    assign res = res_reg;

endmodule

@@ hw/rtl/dtrc_merge.sv @@
// Merging stage: opening angle cut from both roads and the final decision.
// Five pipeline stages in step with the lanes; the last one is the output.
// Depends on dtrc_pkg.
module dtrc_merge
    import dtrc_pkg::*;
(
    input  logic                      clk,
    input  logic [NUM_STAGES-1:0]     en,
    input  logic signed [SLOPE_W-1:0] slope_x_a,
    input  logic signed [SLOPE_W-1:0] slope_y_a,
    input  logic signed [SLOPE_W-1:0] slope_x_b,
    input  logic signed [SLOPE_W-1:0] slope_y_b,
    input  lane_res_t                 lane_a,
    input  lane_res_t                 lane_b,
    input  logic [2*COS_W-1:0]        cos_sq,
    output logic                      accept,
    output reason_t                   fail_reason
);

    localparam int NUM_W = 2*SLOPE_W + 2;
    localparam int PRD_W = 2*MAG_W;
    localparam int CMP_W = 3*MAG_W;

    logic signed [2*SLOPE_W-1:0] pxx;
    logic signed [2*SLOPE_W-1:0] pyy;
    logic signed [2*SLOPE_W-1:0] pxx_reg;
    logic signed [2*SLOPE_W-1:0] pyy_reg;
    logic signed [NUM_W-1:0]     num_reg;
    logic signed [NUM_W-1:0]     num_next;
    logic [MAG_W-1:0]            den_a;
    logic [MAG_W-1:0]            den_b;
    logic [PRD_W-1:0]            n2_s3_reg;
    logic [PRD_W-1:0]            den2_reg;
    logic                        num_pos_s3_reg;
    reason_t                     pre_s3_reg;
    reason_t                     pre_next;
    logic [PRD_W-1:0]            rhs_lo_reg;
    logic [PRD_W-1:0]            rhs_hi_reg;
    logic [PRD_W-1:0]            n2_s4_reg;
    logic                        num_pos_s4_reg;
    reason_t                     pre_s4_reg;
    logic [CMP_W-1:0]            lhs;
    logic [CMP_W-1:0]            rhs;
    logic                        angle_ok;
    reason_t                     reason_next;
    reason_t                     reason_reg;
    logic                        accept_reg;

    // Stage one: cross products of the two roads.
    assign pxx = slope_x_a * slope_x_b;
    assign pyy = slope_y_a * slope_y_b;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pxx_reg <= pxx;
            pyy_reg <= pyy;
        end
    end

    // Stage two: dot product plus one, in Q6.24.
    assign num_next = NUM_W'(pxx_reg) + NUM_W'(pyy_reg)
                    + $signed({2'b00, ONE_SQ});

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            num_reg <= num_next;
        end
    end

    // Stage three: square of the numerator, product of the norms and the
    // outcome of the lane cuts in their order of priority.
    assign den_a = lane_a.mag + ONE_SQ;
    assign den_b = lane_b.mag + ONE_SQ;

    always_comb
    begin
        priority if (!(lane_a.depth_ok && lane_b.depth_ok))
        begin
            pre_next = REASON_DEPTH;
        end
        else if (!(lane_a.count_ok && lane_b.count_ok))
        begin
            pre_next = REASON_HITS;
        end
        else if (!(lane_a.slope_ok && lane_b.slope_ok))
        begin
            pre_next = REASON_SLOPE;
        end
        else
        begin
            pre_next = REASON_PASS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            n2_s3_reg      <= PRD_W'(num_reg[MAG_W-1:0]) * PRD_W'(num_reg[MAG_W-1:0]);
            den2_reg       <= PRD_W'(den_a) * PRD_W'(den_b);
            num_pos_s3_reg <= !num_reg[NUM_W-1] && (num_reg != '0);
            pre_s3_reg     <= pre_next;
        end
    end

    // Stage four: squared cosine limit times the norms, in two halves.
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            rhs_lo_reg     <= PRD_W'(cos_sq) * PRD_W'(den2_reg[MAG_W-1:0]);
            rhs_hi_reg     <= PRD_W'(cos_sq) * PRD_W'(den2_reg[PRD_W-1:MAG_W]);
            n2_s4_reg      <= n2_s3_reg;
            num_pos_s4_reg <= num_pos_s3_reg;
            pre_s4_reg     <= pre_s3_reg;
        end
    end

    // Stage five: num^2 * 2^30 <= cos^2 * den2, unless the cosine is not
    // positive, in which case the angle cut passes.
    assign lhs = {2'b00, n2_s4_reg, 30'd0};
    assign rhs = {rhs_hi_reg, 32'd0} + {32'd0, rhs_lo_reg};
    assign angle_ok = !num_pos_s4_reg || (lhs <= rhs);

    always_comb
    begin
        if (pre_s4_reg != REASON_PASS)
        begin
            reason_next = pre_s4_reg;
        end
        else if (angle_ok)
        begin
            reason_next = REASON_PASS;
        end
        else
        begin
            reason_next = REASON_ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            reason_reg <= reason_next;
            accept_reg <= reason_next == REASON_PASS;
        end
    end

    assign accept      = accept_reg;
    assign fail_reason = reason_reg;

endmodule

@@ hw/rtl/dimuon_trigger_road_cut_top.sv @@
// Top level of the dimuon road cut: stream ports, configuration registers,
// pipeline handshake control, two road lanes and the merging stage.
// Depends on dtrc_pkg, dtrc_lane and dtrc_merge.
//
// Usage:
//   Each input beat on s_axis carries one pair of road candidates: two hit
//   patterns and the x and y slopes of both roads. Each beat yields exactly
//   one output beat on m_axis with the accept flag and the first failing cut
//   (pass, depth, hit count, slope, opening angle).
//   One pair is taken every cycle while the pipeline is not stalled by
//   m_axis_tready; the rate is set by the five-stage pipeline,
//   whose multipliers are each registered (the widest product, squared
//   cosine times the norm product, is split over two 32-bit multipliers).
//   Each stage holds its data while the one after it is full and stalled,
//   so a stall on m_axis_tready fills the empty stages first; s_axis_tready
//   drops only when all five stages hold a beat.
//   Configuration is written through cfg_we, cfg_index and cfg_data; the user must
//   write it only while the pipeline is empty, which the block does not enforce.
//   Reset empties the pipeline and loads the default thresholds: depth 256, 8 hits, slope 871, cosine limit 30946.
module dimuon_trigger_road_cut_top
    import dtrc_pkg::*;
#(
    parameter int PATTERN_BITS = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Fields from bit 0: pattern_a, pattern_b, slope_x_a, slope_y_a,
    // slope_x_b, slope_y_b, zero fill.
    input  logic [((2*PATTERN_BITS+4*SLOPE_W+7)/8)*8-1:0] s_axis_tdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // Fields from bit 0: accept, fail_reason, zero fill.
    output logic [7:0]          m_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam int PA_LSB  = 0;
    localparam int PB_LSB  = PATTERN_BITS;
    localparam int XA_LSB  = 2*PATTERN_BITS;
    localparam int YA_LSB  = XA_LSB + SLOPE_W;
    localparam int XB_LSB  = YA_LSB + SLOPE_W;
    localparam int YB_LSB  = XB_LSB + SLOPE_W;

    logic [DEPTH_W-1:0]        depth_thr_reg;
    logic [HITS_W-1:0]         min_hits_reg;
    logic [MSLOPE_W-1:0]       min_slope_reg;
    logic [COS_W-1:0]          cos_lim_reg;
    logic [2*MSLOPE_W-1:0]     min_slope_sq_next;
    logic [2*MSLOPE_W-1:0]     min_slope_sq_reg;
    logic [2*COS_W-1:0]        cos_sq_next;
    logic [2*COS_W-1:0]        cos_sq_reg;
    logic [NUM_STAGES-1:0]     vld_reg;
    logic [NUM_STAGES-1:0]     rdy;
    logic [NUM_STAGES-1:0]     en;
    logic signed [SLOPE_W-1:0] slope_x_a;
    logic signed [SLOPE_W-1:0] slope_y_a;
    logic signed [SLOPE_W-1:0] slope_x_b;
    logic signed [SLOPE_W-1:0] slope_y_b;
    lane_res_t                 lane_a;
    lane_res_t                 lane_b;
    logic                      accept;
    reason_t                   fail_reason;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_thr_reg <= 10'd256;
            min_hits_reg  <= 4'd8;
            min_slope_reg <= 15'd871;
            cos_lim_reg   <= 16'd30946;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEPTH_THRESHOLD: depth_thr_reg <= cfg_data[DEPTH_W-1:0];
                REG_MIN_HIT_COUNT:   min_hits_reg  <= cfg_data[HITS_W-1:0];
                REG_MIN_SLOPE:       min_slope_reg <= cfg_data[MSLOPE_W-1:0];
                REG_COS_ANGLE_LIMIT: cos_lim_reg   <= cfg_data[COS_W-1:0];
                default:             depth_thr_reg <= depth_thr_reg;
            endcase
        end
    end

    // Squared thresholds, refreshed every cycle from the registers.
    assign min_slope_sq_next = min_slope_reg * min_slope_reg;
    assign cos_sq_next       = cos_lim_reg * cos_lim_reg;

    always_ff @(posedge clk)
    begin
        min_slope_sq_reg <= min_slope_sq_next;
        cos_sq_reg       <= cos_sq_next;
    end

    // A stage may load when it is empty or its successor moves on.
    always_comb
    begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        en[0] = rdy[0] && s_axis_tvalid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            en[k] = rdy[k] && vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = vld_reg[NUM_STAGES-1];

    // Input beat unpacking.
    assign slope_x_a = s_axis_tdata[XA_LSB +: SLOPE_W];
    assign slope_y_a = s_axis_tdata[YA_LSB +: SLOPE_W];
    assign slope_x_b = s_axis_tdata[XB_LSB +: SLOPE_W];
    assign slope_y_b = s_axis_tdata[YB_LSB +: SLOPE_W];

    // One lane per road.
    dtrc_lane #(
        .PATTERN_BITS (PATTERN_BITS)
    ) u_lane_a (
        .clk             (clk),
        .en              (en[1:0]),
        .pattern         (s_axis_tdata[PA_LSB +: PATTERN_BITS]),
        .slope_x         (slope_x_a),
        .slope_y         (slope_y_a),
        .depth_threshold (depth_thr_reg),
        .min_hit_count   (min_hits_reg),
        .min_slope_sq    (min_slope_sq_reg),
        .res             (lane_a)
    );

    dtrc_lane #(
        .PATTERN_BITS (PATTERN_BITS)
    ) u_lane_b (
        .clk             (clk),
        .en              (en[1:0]),
        .pattern         (s_axis_tdata[PB_LSB +: PATTERN_BITS]),
        .slope_x         (slope_x_b),
        .slope_y         (slope_y_b),
        .depth_threshold (depth_thr_reg),
        .min_hit_count   (min_hits_reg),
        .min_slope_sq    (min_slope_sq_reg),
        .res             (lane_b)
    );

    // Angle cut and final decision.
    dtrc_merge u_merge (
        .clk         (clk),
        .en          (en),
        .slope_x_a   (slope_x_a),
        .slope_y_a   (slope_y_a),
        .slope_x_b   (slope_x_b),
        .slope_y_b   (slope_y_b),
        .lane_a      (lane_a),
        .lane_b      (lane_b),
        .cos_sq      (cos_sq_reg),
        .accept      (accept),
        .fail_reason (fail_reason)
    );

    assign m_axis_tdata = {4'd0, fail_reason, accept};

`ifndef SYNTHESIS
    // The accept flag agrees with the reported reason.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (accept == (fail_reason == REASON_PASS)))
        else $error("accept flag disagrees with fail_reason");

    // Input is held off only when every stage holds a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (vld_reg == {NUM_STAGES{1'b1}}))
        else $error("input stalled while a pipeline stage is empty");

    // Beats in flight change only by beats taken in and handed out.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
            ($countones(vld_reg) + int'($past(m_axis_tvalid && m_axis_tready))
             == $past($countones(vld_reg))
                + int'($past(s_axis_tvalid && s_axis_tready))))
        else $error("pipeline occupancy lost or invented a beat");
`endif

endmodule
